[sv/c_tsc_pkg.sv]
// ----------------------------------------------------------------------------
// c_tsc_pkg
// Types and codes shared by the C type specifier checker: request and result
// payloads, keyword, category and error codes, flag bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package c_tsc_pkg;

  localparam int unsigned FlagsW    = 11;
  localparam int unsigned CategoryW = 4;
  localparam int unsigned ErrorW    = 3;
  localparam int unsigned SpecW     = 4;

  // flag bit positions in type_flags
  localparam int unsigned FlagSigned   = 0;
  localparam int unsigned FlagUnsigned = 1;
  localparam int unsigned FlagComplex  = 2;
  localparam int unsigned FlagImag     = 3;
  localparam int unsigned FlagConst    = 4;
  localparam int unsigned FlagRestrict = 5;
  localparam int unsigned FlagVolatile = 6;
  localparam int unsigned FlagPointer  = 7;
  localparam int unsigned FlagPConst   = 8;
  localparam int unsigned FlagPRestr   = 9;
  localparam int unsigned FlagPVol     = 10;

  // action codes
  localparam logic ActBegin = 1'b0;
  localparam logic ActApply = 1'b1;

  typedef enum logic [SpecW-1:0] {
    SPEC_VOID      = 4'd0,
    SPEC_CHAR      = 4'd1,
    SPEC_SHORT     = 4'd2,
    SPEC_INT       = 4'd3,
    SPEC_LONG      = 4'd4,
    SPEC_FLOAT     = 4'd5,
    SPEC_DOUBLE    = 4'd6,
    SPEC_SIGNED    = 4'd7,
    SPEC_UNSIGNED  = 4'd8,
    SPEC_BOOL      = 4'd9,
    SPEC_COMPLEX   = 4'd10,
    SPEC_IMAGINARY = 4'd11,
    SPEC_CONST     = 4'd12,
    SPEC_RESTRICT  = 4'd13,
    SPEC_VOLATILE  = 4'd14,
    SPEC_STAR      = 4'd15
  } spec_e;

  typedef enum logic [CategoryW-1:0] {
    CAT_NONE    = 4'd0,
    CAT_CHAR    = 4'd1,
    CAT_SHORT   = 4'd2,
    CAT_INT     = 4'd3,
    CAT_LONG    = 4'd4,
    CAT_LLONG   = 4'd5,
    CAT_FLOAT   = 4'd6,
    CAT_DOUBLE  = 4'd7,
    CAT_LDOUBLE = 4'd8,
    CAT_VOID    = 4'd9,
    CAT_BOOL    = 4'd10
  } cat_e;

  typedef enum logic [ErrorW-1:0] {
    ERR_NONE          = 3'd0,
    ERR_MIX           = 3'd1,
    ERR_SIGN_TYPE     = 3'd2,
    ERR_CPX_INT       = 3'd3,
    ERR_SIGN_CONFLICT = 3'd4,
    ERR_CPX_CONFLICT  = 3'd5
  } err_e;

  typedef struct packed {
    logic             action;
    logic [SpecW-1:0] specifier;
  } req_t;

  typedef struct packed {
    logic                 accepted;
    logic [ErrorW-1:0]    error_code;
    logic [CategoryW-1:0] category;
    logic [FlagsW-1:0]    type_flags;
  } rsp_t;

endpackage

`default_nettype wire

[sv/c_type_specifier_checker_unit.sv]
// ----------------------------------------------------------------------------
// c_type_specifier_checker_unit
// Accumulates C declaration-specifier keywords into a base category and
// eleven type flags, flagging illegal combinations with a sticky error code.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_ready_o carry one request (in_req_i) that
//                 either begins a new declaration or applies one keyword.
//   out channel : out_valid_o / out_ready_i carry one result (out_rsp_o) per
//                 request: accepted flag plus the type state after the keyword.
//   path        : a request passes the input register, then the result register,
//                 which is written together with the declaration state.
//   throughput  : one request per cycle unless out_ready_i stalls; the keyword
//                 update is a small case over category and flag registers fed back.
//   stall       : both stages hold while out_ready_i is low and full; in_ready_o
//                 drops only when the input register is occupied and cannot move.
//   reset       : rst_ni clears the category, flags, sticky error and both
//                 valid bits; the block takes a request in the first cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module c_type_specifier_checker_unit (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output logic                     in_ready_o,
  input  wire c_tsc_pkg::req_t     in_req_i,
  output logic                     out_valid_o,
  input  wire                logic out_ready_i,
  output c_tsc_pkg::rsp_t          out_rsp_o
);

  localparam int unsigned FlagsW    = c_tsc_pkg::FlagsW;
  localparam int unsigned CategoryW = c_tsc_pkg::CategoryW;
  localparam int unsigned ErrorW    = c_tsc_pkg::ErrorW;

  // input register
  logic            in_vld_q;
  c_tsc_pkg::req_t in_req_q;

  // declaration state
  logic [CategoryW-1:0] cat_q, cat_d;
  logic [FlagsW-1:0]    flags_q, flags_d;
  logic [ErrorW-1:0]    err_q, err_d;

  // result register
  logic            out_vld_q;
  c_tsc_pkg::rsp_t out_rsp_q, out_rsp_d;

  logic advance;   // input register moves into the result register
  logic in_take;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // keyword evaluation
  logic                 sgn, cpx, is_int;
  logic [CategoryW-1:0] c_new;
  logic [FlagsW-1:0]    f_new;
  logic [ErrorW-1:0]    code;
  logic                 star_rej;
  logic                 acc;

  always_comb begin
    sgn      = flags_q[c_tsc_pkg::FlagSigned] | flags_q[c_tsc_pkg::FlagUnsigned];
    cpx      = flags_q[c_tsc_pkg::FlagComplex] | flags_q[c_tsc_pkg::FlagImag];
    is_int   = (cat_q >= c_tsc_pkg::CAT_CHAR) && (cat_q <= c_tsc_pkg::CAT_LLONG);
    c_new    = cat_q;
    f_new    = flags_q;
    code     = c_tsc_pkg::ERR_NONE;
    star_rej = 1'b0;

    unique case (c_tsc_pkg::spec_e'(in_req_q.specifier))
      c_tsc_pkg::SPEC_VOID: begin
        if (sgn) code = c_tsc_pkg::ERR_SIGN_TYPE;
        else if (cpx || cat_q != c_tsc_pkg::CAT_NONE) code = c_tsc_pkg::ERR_MIX;
        else c_new = c_tsc_pkg::CAT_VOID;
      end
      c_tsc_pkg::SPEC_CHAR: begin
        if (cpx) code = c_tsc_pkg::ERR_CPX_INT;
        else if (cat_q != c_tsc_pkg::CAT_NONE) code = c_tsc_pkg::ERR_MIX;
        else c_new = c_tsc_pkg::CAT_CHAR;
      end
      c_tsc_pkg::SPEC_SHORT: begin
        if (cpx) code = c_tsc_pkg::ERR_CPX_INT;
        else if (cat_q != c_tsc_pkg::CAT_NONE && cat_q != c_tsc_pkg::CAT_INT)
          code = c_tsc_pkg::ERR_MIX;
        else c_new = c_tsc_pkg::CAT_SHORT;
      end
      c_tsc_pkg::SPEC_INT: begin
        // int after short or long keeps the wider category
        if (cpx) code = c_tsc_pkg::ERR_CPX_INT;
        else if (cat_q == c_tsc_pkg::CAT_SHORT || cat_q == c_tsc_pkg::CAT_LONG ||
                 cat_q == c_tsc_pkg::CAT_LLONG) c_new = cat_q;
        else if (cat_q != c_tsc_pkg::CAT_NONE) code = c_tsc_pkg::ERR_MIX;
        else c_new = c_tsc_pkg::CAT_INT;
      end
      c_tsc_pkg::SPEC_LONG: begin
        if (cat_q == c_tsc_pkg::CAT_NONE || cat_q == c_tsc_pkg::CAT_INT)
          c_new = c_tsc_pkg::CAT_LONG;
        else if (cat_q == c_tsc_pkg::CAT_LONG) c_new = c_tsc_pkg::CAT_LLONG;
        else if (cat_q == c_tsc_pkg::CAT_DOUBLE) c_new = c_tsc_pkg::CAT_LDOUBLE;
        else code = c_tsc_pkg::ERR_MIX;
      end
      c_tsc_pkg::SPEC_FLOAT: begin
        if (sgn) code = c_tsc_pkg::ERR_SIGN_TYPE;
        else if (cat_q != c_tsc_pkg::CAT_NONE) code = c_tsc_pkg::ERR_MIX;
        else c_new = c_tsc_pkg::CAT_FLOAT;
      end
      c_tsc_pkg::SPEC_DOUBLE: begin
        if (sgn) code = c_tsc_pkg::ERR_SIGN_TYPE;
        else if (cat_q == c_tsc_pkg::CAT_NONE) c_new = c_tsc_pkg::CAT_DOUBLE;
        else if (cat_q == c_tsc_pkg::CAT_LONG) c_new = c_tsc_pkg::CAT_LDOUBLE;
        else code = c_tsc_pkg::ERR_MIX;
      end
      c_tsc_pkg::SPEC_SIGNED: begin
        if (cat_q >= c_tsc_pkg::CAT_FLOAT) code = c_tsc_pkg::ERR_SIGN_TYPE;
        else if (flags_q[c_tsc_pkg::FlagUnsigned]) code = c_tsc_pkg::ERR_SIGN_CONFLICT;
        else f_new[c_tsc_pkg::FlagSigned] = 1'b1;
      end
      c_tsc_pkg::SPEC_UNSIGNED: begin
        if (cat_q >= c_tsc_pkg::CAT_FLOAT) code = c_tsc_pkg::ERR_SIGN_TYPE;
        else if (flags_q[c_tsc_pkg::FlagSigned]) code = c_tsc_pkg::ERR_SIGN_CONFLICT;
        else f_new[c_tsc_pkg::FlagUnsigned] = 1'b1;
      end
      c_tsc_pkg::SPEC_BOOL: begin
        if (sgn) code = c_tsc_pkg::ERR_SIGN_TYPE;
        else if (cat_q != c_tsc_pkg::CAT_NONE) code = c_tsc_pkg::ERR_MIX;
        else c_new = c_tsc_pkg::CAT_BOOL;
      end
      c_tsc_pkg::SPEC_COMPLEX: begin
        if (is_int) code = c_tsc_pkg::ERR_CPX_INT;
        else if (flags_q[c_tsc_pkg::FlagImag]) code = c_tsc_pkg::ERR_CPX_CONFLICT;
        else f_new[c_tsc_pkg::FlagComplex] = 1'b1;
      end
      c_tsc_pkg::SPEC_IMAGINARY: begin
        if (is_int) code = c_tsc_pkg::ERR_CPX_INT;
        else if (flags_q[c_tsc_pkg::FlagComplex]) code = c_tsc_pkg::ERR_CPX_CONFLICT;
        else f_new[c_tsc_pkg::FlagImag] = 1'b1;
      end
      // qualifiers after the star apply to the pointer
      c_tsc_pkg::SPEC_CONST: begin
        if (flags_q[c_tsc_pkg::FlagPointer]) f_new[c_tsc_pkg::FlagPConst] = 1'b1;
        else f_new[c_tsc_pkg::FlagConst] = 1'b1;
      end
      c_tsc_pkg::SPEC_RESTRICT: begin
        if (flags_q[c_tsc_pkg::FlagPointer]) f_new[c_tsc_pkg::FlagPRestr] = 1'b1;
        else f_new[c_tsc_pkg::FlagRestrict] = 1'b1;
      end
      c_tsc_pkg::SPEC_VOLATILE: begin
        if (flags_q[c_tsc_pkg::FlagPointer]) f_new[c_tsc_pkg::FlagPVol] = 1'b1;
        else f_new[c_tsc_pkg::FlagVolatile] = 1'b1;
      end
      c_tsc_pkg::SPEC_STAR: begin
        // second star is refused without an error
        if (flags_q[c_tsc_pkg::FlagPointer]) star_rej = 1'b1;
        else f_new[c_tsc_pkg::FlagPointer] = 1'b1;
      end
      default: begin
        code = c_tsc_pkg::ERR_NONE;
      end
    endcase
  end

  // state update and result
  always_comb begin
    cat_d   = cat_q;
    flags_d = flags_q;
    err_d   = err_q;
    acc     = 1'b0;

    if (in_req_q.action == c_tsc_pkg::ActBegin) begin
      cat_d   = c_tsc_pkg::CAT_NONE;
      flags_d = '0;
      err_d   = c_tsc_pkg::ERR_NONE;
    end else if (err_q == c_tsc_pkg::ERR_NONE) begin
      if (code != c_tsc_pkg::ERR_NONE) begin
        err_d = code;  // state keeps its value from before the keyword
      end else if (!star_rej) begin
        cat_d   = c_new;
        flags_d = f_new;
        acc     = 1'b1;
      end
    end

    out_rsp_d.accepted   = acc;
    out_rsp_d.error_code = err_d;
    out_rsp_d.category   = cat_d;
    out_rsp_d.type_flags = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cat_q     <= c_tsc_pkg::CAT_NONE;
      flags_q   <= '0;
      err_q     <= c_tsc_pkg::ERR_NONE;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        cat_q     <= cat_d;
        flags_q   <= flags_d;
        err_q     <= err_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  // an accepted keyword never carries an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.accepted |-> out_rsp_o.error_code == c_tsc_pkg::ERR_NONE)
    else $error("accepted keyword reported with an error code");

  // pointer qualifiers only exist once the pointer is marked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q[c_tsc_pkg::FlagPConst] || flags_q[c_tsc_pkg::FlagPRestr] ||
     flags_q[c_tsc_pkg::FlagPVol]) |-> flags_q[c_tsc_pkg::FlagPointer])
    else $error("pointer qualifier without pointer");

  // signed and unsigned, complex and imaginary exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags_q[c_tsc_pkg::FlagSigned] && flags_q[c_tsc_pkg::FlagUnsigned]) &&
    !(flags_q[c_tsc_pkg::FlagComplex] && flags_q[c_tsc_pkg::FlagImag]))
    else $error("conflicting sign or complex flags held");

  // state only changes when a request moves into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(cat_q) && $stable(flags_q) && $stable(err_q))
    else $error("declaration state changed without a request");

endmodule

`default_nettype wire
